// ===== rtl/core/gwt_pkg.sv =====
// Package for the word tokenizer: request/result structs, scan phases,
// character constants and character-class helpers. No dependencies.
`timescale 1ns / 1ps

package gwt_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } gwt_req_t;

  typedef struct packed {
    logic [7:0] char_code_res;
    logic       last_in_word;
  } gwt_res_t;

  typedef enum logic [2:0] {
    PH_BETWEEN    = 3'd0,
    PH_SKIP_TOKEN = 3'd1,
    PH_IN_WORD    = 3'd2,
    PH_SKIP_LINE  = 3'd3,
    PH_SKIP_ENDS  = 3'd4,
    PH_SKIP_BLANK = 3'd5
  } gwt_phase_e;

  // Per-request word actions, applied in declaration order
  typedef struct packed {
    logic clear;
    logic clr_hyph;
    logic app_hyph;
    logic word_byte;
    logic app_char;
    logic flush;
  } gwt_act_t;

  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChHyphen = 8'h2D;
  localparam logic [7:0] ChPipe   = 8'h7C;
  localparam logic [7:0] ChTilde  = 8'h7E;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_line_end(logic [7:0] c);
    return (c == ChCr) || (c == ChLf) || (c == ChVt);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

// ===== rtl/core/greek_word_tokenizer_unit.sv =====
// Top level of the word tokenizer: scan-phase control, word assembly and a
// four-entry result queue. Depends on gwt_pkg.
`timescale 1ns / 1ps
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-----------------------------
//  in      | in  | in_valid_i / in_stall_o | in_req_i  (gwt_req_t)
//  out     | out | out_valid_o/out_stall_i | out_res_o (gwt_res_t)
//
// One request is taken per cycle while in_stall_o is low; it yields zero,
// one or two results that enter the result queue at the same edge. The
// queue drains one result per cycle while out_stall_i is low, so the
// sustained rate is one request per cycle unless requests yield two results
// (output-paced). in_stall_o rises when fewer than two queue slots are free.
// Reset puts the scanner between words with an empty word and empty queue.

module greek_word_tokenizer_unit
  import gwt_pkg::*;
#(
  parameter int WORD_CHARS = 63
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gwt_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gwt_res_t out_res_o
);

  localparam int LenW = $clog2(WORD_CHARS + 1);

  typedef struct packed {
    logic [7:0]      held;
    logic            hv;
    logic            hyph;
    logic [LenW-1:0] len;
    logic [1:0]      n;
    gwt_res_t        r0;
    gwt_res_t        r1;
  } ctx_t;

  function automatic ctx_t do_emit(ctx_t x, logic [7:0] c, logic last);
    ctx_t y;
    y = x;
    if (x.n == 2'd0) begin
      y.r0 = '{char_code_res: c, last_in_word: last};
    end else begin
      y.r1 = '{char_code_res: c, last_in_word: last};
    end
    y.n = x.n + 2'd1;
    return y;
  endfunction

  function automatic ctx_t do_append(ctx_t x, logic [7:0] c);
    ctx_t y;
    y = x;
    if (x.len < LenW'(WORD_CHARS)) begin
      if (x.hv) begin
        y = do_emit(y, x.held, 1'b0);
      end
      y.held = c;
      y.hv   = 1'b1;
      y.len  = x.len + LenW'(1);
    end
    return y;
  endfunction

  function automatic ctx_t do_word_byte(ctx_t x, logic [7:0] c);
    ctx_t y;
    y = x;
    if (c == ChPipe || c == ChLBrack || c == ChRBrack || is_digit(c)) begin
      y = x;
    end else if (c == ChHyphen) begin
      y.hyph = 1'b1;
    end else begin
      y = do_append(x, c);
    end
    return y;
  endfunction

  function automatic ctx_t do_clear(ctx_t x);
    ctx_t y;
    y      = x;
    y.held = '0;
    y.hv   = 1'b0;
    y.hyph = 1'b0;
    y.len  = '0;
    return y;
  endfunction

  // Scanner state
  gwt_phase_e      phase_q, phase_d;
  logic [7:0]      held_q;
  logic            hv_q, hyph_q;
  logic [LenW-1:0] len_q;

  // Result queue
  gwt_res_t   fifo_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;

  logic       in_acc, out_acc;
  logic [7:0] c;
  gwt_act_t   act;
  ctx_t       ctx;

  assign in_stall_o  = (cnt_q > 3'd2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_res_o   = fifo_q[rd_q];
  assign c           = in_req_i.char_code;

  // Next phase and word actions
  always_comb begin
    phase_d = phase_q;
    act     = '0;
    if (in_req_i.end_of_text) begin
      act.app_hyph = (phase_q == PH_IN_WORD) && hyph_q;
      act.flush    = 1'b1;
      phase_d      = PH_BETWEEN;
    end else begin
      unique case (phase_q)
        PH_BETWEEN: begin
          if (!is_blank(c)) begin
            if (is_digit(c) || c == ChTilde) begin
              phase_d = PH_SKIP_TOKEN;
            end else begin
              act.clear     = 1'b1;
              act.word_byte = 1'b1;
              phase_d       = PH_IN_WORD;
            end
          end
        end
        PH_SKIP_TOKEN: begin
          if (is_blank(c)) begin
            phase_d = PH_BETWEEN;
          end
        end
        PH_IN_WORD: begin
          if (hyph_q) begin
            act.clr_hyph = 1'b1;
            if (is_blank(c)) begin
              phase_d = is_line_end(c) ? PH_SKIP_ENDS : PH_SKIP_LINE;
            end else begin
              act.app_hyph  = 1'b1;
              act.word_byte = 1'b1;
            end
          end else if (is_blank(c)) begin
            act.flush = 1'b1;
            phase_d   = PH_BETWEEN;
          end else begin
            act.word_byte = 1'b1;
          end
        end
        PH_SKIP_LINE: begin
          if (is_line_end(c)) begin
            phase_d = PH_SKIP_ENDS;
          end
        end
        PH_SKIP_ENDS: begin
          priority if (is_line_end(c)) begin
            phase_d = PH_SKIP_ENDS;
          end else if (c == ChTilde) begin
            phase_d = PH_SKIP_LINE;
          end else if (is_blank(c)) begin
            phase_d = PH_SKIP_BLANK;
          end else begin
            act.app_char = 1'b1;
            phase_d      = PH_IN_WORD;
          end
        end
        PH_SKIP_BLANK: begin
          if (!is_blank(c)) begin
            act.app_char = 1'b1;
            phase_d      = PH_IN_WORD;
          end
        end
        default: begin
          act.clear = 1'b1;
          phase_d   = PH_BETWEEN;
        end
      endcase
    end
  end

  // Word assembly and result generation
  always_comb begin
    ctx      = '0;
    ctx.held = held_q;
    ctx.hv   = hv_q;
    ctx.hyph = hyph_q;
    ctx.len  = len_q;
    if (act.clear) begin
      ctx = do_clear(ctx);
    end
    if (act.clr_hyph) begin
      ctx.hyph = 1'b0;
    end
    if (act.app_hyph) begin
      ctx = do_append(ctx, ChHyphen);
    end
    if (act.word_byte) begin
      ctx = do_word_byte(ctx, c);
    end
    if (act.app_char) begin
      ctx = do_append(ctx, c);
    end
    if (act.flush) begin
      if (ctx.hv) begin
        ctx = do_emit(ctx, ctx.held, 1'b1);
      end
      ctx = do_clear(ctx);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc) begin
      cnt_d = cnt_d + {1'b0, ctx.n};
    end
    if (out_acc) begin
      cnt_d = cnt_d - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BETWEEN;
      held_q  <= '0;
      hv_q    <= 1'b0;
      hyph_q  <= 1'b0;
      len_q   <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (out_acc) begin
        rd_q <= rd_q + 2'd1;
      end
      if (in_acc) begin
        phase_q <= phase_d;
        held_q  <= ctx.held;
        hv_q    <= ctx.hv;
        hyph_q  <= ctx.hyph;
        len_q   <= ctx.len;
        wr_q    <= wr_q + ctx.n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (ctx.n != 2'd0) begin
        fifo_q[wr_q] <= ctx.r0;
      end
      if (ctx.n == 2'd2) begin
        fifo_q[wr_q + 2'd1] <= ctx.r1;
      end
    end
  end

endmodule
